@@ rtl/core/lspg_pkg.sv @@
package lspg_pkg;

    typedef enum logic [2:0] {
        MODE_SLEEP     = 3'd0,
        MODE_LISTENING = 3'd1,
        MODE_THINKING  = 3'd2,
        MODE_SPEAKING  = 3'd3,
        MODE_ERROR     = 3'd4,
        MODE_BOOT      = 3'd5
    } mode_t;

    // minimum spacing of accepted updates
    localparam logic [31:0] GAP_MS = 32'd40;

    // time bases
    localparam int unsigned THINK_STEP   = 90;
    localparam int unsigned BOOT_STEP    = 60;
    localparam int unsigned BLINK_PERIOD = 320;
    localparam int unsigned GLOW_PERIOD  = 4200;
    localparam int unsigned GLOW_HALF    = 2100;
    // 28 * up / 2100 == up / 75
    localparam int unsigned GLOW_DIV     = 75;
    localparam logic [5:0]  GLOW_BASE    = 6'd6;

    // reciprocal shifts for constant division
    localparam int unsigned MOD_SHIFT = 32;
    localparam int unsigned DIV_SHIFT = 24;

    localparam int unsigned COMET_LEN = 4;
    localparam logic [7:0] COMET_R [COMET_LEN] = '{8'd127, 8'd63, 8'd31, 8'd15};
    localparam logic [7:0] COMET_G [COMET_LEN] = '{8'd50, 8'd25, 8'd12, 8'd6};

    localparam logic [7:0] MUTE_R    = 8'd40;
    localparam logic [7:0] LISTEN_G  = 8'd60;
    localparam logic [7:0] LISTEN_B  = 8'd150;
    localparam logic [7:0] SPEAK_R   = 8'd255;
    localparam logic [7:0] SPEAK_G   = 8'd90;
    localparam logic [7:0] ERROR_R   = 8'd180;
    localparam logic [7:0] BOOT_G    = 8'd120;
    localparam logic [7:0] BOOT_B    = 8'd200;

    localparam logic [7:0] BRIGHTNESS_RESET = 8'd255;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] audio_level;
        logic       server_online;
        logic       muted;
    } side_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       muted;
        logic       server_online;
        logic       blink;
        logic [6:0] lit;
        logic [5:0] head;
        logic [5:0] boot_pos;
        logic [5:0] glow;
    } frame_cfg_t;

endpackage

@@ rtl/core/led_status_pattern_generator.sv @@
// LED status pattern generator.
// Request channel (req_valid/req_stall): one update word per handshake with
// mode, audio_level, server_online, muted and now_ms. A word arriving less
// than 40 ms (wrapping difference) after the last taken update yields
// nothing; otherwise it becomes one frame of PIXEL_COUNT pixel words on the
// pixel channel (pix_valid/pix_stall), index 0 first, frame_last on the end.
// Configuration: cfg_write_en/cfg_write_data set brightness, copied to level.
// Path: a request reaches the first pixel of its frame through the input
// register, six-stage constant modulo pipeline, parameter stage, frame
// config register with pixel counter, and pixel register. Throughput:
// requests that give no frame go at one per cycle unless the pipeline is
// held; frames leave at one pixel per cycle unless pix_stall holds them,
// and a frame holds the frame generator and the pipeline to its last pixel.
// Reset: last update time returns to 0 (so requests with now_ms below 40 are
// dropped), brightness to 255, all stages empty.
// Stall: pix_stall freezes the pixel register and, once the pipeline backs
// up, req_stall rises; nothing is dropped or repeated.
module led_status_pattern_generator #(
    parameter int PIXEL_COUNT = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  audio_level,
    input  logic        server_online,
    input  logic        muted,
    input  logic [31:0] now_ms,
    output logic        pix_valid,
    input  logic        pix_stall,
    output logic [5:0]  pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  level,
    output logic        frame_last
);
    import lspg_pkg::*;

    localparam int MOD_LAT = 6;
    localparam int unsigned K_THINK = THINK_STEP * PIXEL_COUNT;
    localparam int unsigned K_BOOT  = BOOT_STEP * PIXEL_COUNT;
    localparam int unsigned K_BLINK = 2 * BLINK_PERIOD;
    localparam int unsigned K_GLOW  = GLOW_PERIOD;
    localparam int RW_THINK = $clog2(K_THINK);
    localparam int RW_BOOT  = $clog2(K_BOOT);
    localparam int RW_BLINK = $clog2(K_BLINK);
    localparam int RW_GLOW  = $clog2(K_GLOW);
    localparam int PW = DIV_SHIFT + 8;
    localparam longint unsigned M_THINK = ((64'd1 << DIV_SHIFT) + THINK_STEP - 1) / THINK_STEP;
    localparam longint unsigned M_BOOT  = ((64'd1 << DIV_SHIFT) + BOOT_STEP - 1) / BOOT_STEP;
    localparam longint unsigned M_GLOW  = ((64'd1 << DIV_SHIFT) + GLOW_DIV - 1) / GLOW_DIV;
    localparam logic [9:0] COUNT10 = 10'(PIXEL_COUNT);

    logic [7:0]          brightness_reg;
    logic [31:0]         last_time_reg;
    logic                req_full_reg;
    side_t               req_reg;
    logic [31:0]         now_reg;
    logic [MOD_LAT-1:0]  valid_reg;
    side_t               side_reg [MOD_LAT];
    logic                g_valid_reg;
    frame_cfg_t          g_cfg_reg;

    logic                adv;
    logic                emit_ok;
    logic                frame_ready;
    logic [RW_THINK-1:0] r_think;
    logic [RW_BOOT-1:0]  r_boot;
    logic [RW_BLINK-1:0] r_blink;
    logic [RW_GLOW-1:0]  r_glow;
    logic [PW-1:0]       think_prod;
    logic [PW-1:0]       boot_prod;
    logic [PW-1:0]       glow_prod;
    logic [11:0]         glow_up;
    logic [9:0]          lit_raw;
    frame_cfg_t          g_cfg_next;

    assign adv       = !g_valid_reg || frame_ready;
    assign req_stall = req_full_reg && !adv;
    assign emit_ok   = req_full_reg && ((now_reg - last_time_reg) >= GAP_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RESET;
            last_time_reg  <= '0;
            req_full_reg   <= 1'b0;
            valid_reg      <= '0;
            g_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                brightness_reg <= cfg_write_data;
            end
            if (!req_full_reg || adv)
            begin
                req_full_reg <= req_valid;
            end
            if (adv)
            begin
                valid_reg   <= {valid_reg[MOD_LAT-2:0], emit_ok};
                g_valid_reg <= valid_reg[MOD_LAT-1];
                if (emit_ok)
                begin
                    last_time_reg <= now_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= '{mode: mode, audio_level: audio_level,
                         server_online: server_online, muted: muted};
            now_reg <= now_ms;
        end
        if (adv)
        begin
            side_reg[0] <= req_reg;
            for (int k = 1; k < MOD_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
            g_cfg_reg <= g_cfg_next;
        end
    end

    lspg_mod_const #(.K(K_THINK)) u_mod_think (
        .clk     (clk),
        .en      (adv),
        .value   (now_reg),
        .residue (r_think)
    );

    lspg_mod_const #(.K(K_BOOT)) u_mod_boot (
        .clk     (clk),
        .en      (adv),
        .value   (now_reg),
        .residue (r_boot)
    );

    lspg_mod_const #(.K(K_BLINK)) u_mod_blink (
        .clk     (clk),
        .en      (adv),
        .value   (now_reg),
        .residue (r_blink)
    );

    lspg_mod_const #(.K(K_GLOW)) u_mod_glow (
        .clk     (clk),
        .en      (adv),
        .value   (now_reg),
        .residue (r_glow)
    );

    // frame parameters from the residues
    always_comb
    begin
        think_prod = PW'(r_think) * PW'(M_THINK);
        boot_prod  = PW'(r_boot) * PW'(M_BOOT);
        glow_up    = (r_glow < RW_GLOW'(GLOW_HALF)) ? 12'(r_glow)
                                                  : 12'(RW_GLOW'(GLOW_PERIOD) - r_glow);
        glow_prod  = PW'(glow_up) * PW'(M_GLOW);
        lit_raw    = 10'd2 + {1'b0, side_reg[MOD_LAT-1].audio_level, 1'b0};

        g_cfg_next.mode          = side_reg[MOD_LAT-1].mode;
        g_cfg_next.muted         = side_reg[MOD_LAT-1].muted;
        g_cfg_next.server_online = side_reg[MOD_LAT-1].server_online;
        g_cfg_next.blink         = (r_blink >= RW_BLINK'(BLINK_PERIOD));
        g_cfg_next.lit           = (lit_raw > COUNT10) ? 7'(PIXEL_COUNT) : lit_raw[6:0];
        g_cfg_next.head          = think_prod[DIV_SHIFT +: 6];
        g_cfg_next.boot_pos      = boot_prod[DIV_SHIFT +: 6];
        g_cfg_next.glow          = GLOW_BASE + glow_prod[DIV_SHIFT +: 6];
    end

    lspg_frame #(.PIXEL_COUNT(PIXEL_COUNT)) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (g_valid_reg),
        .load_ready  (frame_ready),
        .load_cfg    (g_cfg_reg),
        .brightness  (brightness_reg),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .level       (level),
        .frame_last  (frame_last)
    );

endmodule

@@ rtl/core/lspg_mod_const.sv @@
module lspg_mod_const #(
    parameter int unsigned K = 4200
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [31:0]          value,
    output logic [$clog2(K)-1:0] residue
);
    import lspg_pkg::*;

    localparam int RW = $clog2(K);
    localparam int XW = ((2 * RW > 16) ? 2 * RW : 16) + 1;
    localparam longint unsigned INV_L = (64'd1 << MOD_SHIFT) / K;
    localparam logic [31:0] INV = INV_L[31:0];
    localparam int unsigned C = 65536 % K;
    localparam logic [15:0] K16 = 16'(K);
    localparam logic [XW-1:0] KX = XW'(K);

    logic [47:0]      a_prod_reg;
    logic [15:0]      a_hi_reg;
    logic [15:0]      a_lo_reg;
    logic [15:0]      b_p_reg;
    logic [15:0]      b_hi_reg;
    logic [15:0]      b_lo_reg;
    logic [2*RW-1:0]  c_t_reg;
    logic [15:0]      c_lo_reg;
    logic [XW+31:0]   d_prod_reg;
    logic [XW-1:0]    d_x_reg;
    logic [XW-1:0]    e_p_reg;
    logic [XW-1:0]    e_x_reg;
    logic [RW-1:0]    f_r_reg;

    logic [15:0]      q1;
    logic [15:0]      hi_diff;
    logic [RW-1:0]    hi_res;
    logic [XW-1:0]    x_sum;
    logic [XW-1:0]    q2;
    logic [XW-1:0]    x_diff;

    always_comb
    begin
        q1      = a_prod_reg[47:32];
        hi_diff = b_hi_reg - b_p_reg;
        hi_res  = (hi_diff >= K16) ? RW'(hi_diff - K16) : RW'(hi_diff);
        x_sum   = XW'(c_t_reg) + XW'(c_lo_reg);
        q2      = d_prod_reg[XW+31:32];
        x_diff  = e_x_reg - e_p_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // high half mod K
            a_prod_reg <= 48'(value[31:16]) * 48'(INV);
            a_hi_reg   <= value[31:16];
            a_lo_reg   <= value[15:0];
            b_p_reg    <= 16'(32'(q1) * 32'(K));
            b_hi_reg   <= a_hi_reg;
            b_lo_reg   <= a_lo_reg;
            // fold: (hi mod K) * (2^16 mod K) + lo
            c_t_reg    <= (2*RW)'(hi_res) * (2*RW)'(C);
            c_lo_reg   <= b_lo_reg;
            d_prod_reg <= (XW+32)'(x_sum) * (XW+32)'(INV);
            d_x_reg    <= x_sum;
            e_p_reg    <= XW'(q2 * KX);
            e_x_reg    <= d_x_reg;
            f_r_reg    <= (x_diff >= KX) ? RW'(x_diff - KX) : RW'(x_diff);
        end
    end

    assign residue = f_r_reg;

endmodule

@@ rtl/core/lspg_frame.sv @@
module lspg_frame #(
    parameter int PIXEL_COUNT = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_valid,
    output logic                load_ready,
    input  lspg_pkg::frame_cfg_t load_cfg,
    input  logic [7:0]          brightness,
    output logic                pix_valid,
    input  logic                pix_stall,
    output logic [5:0]          pixel_index,
    output logic [7:0]          red,
    output logic [7:0]          green,
    output logic [7:0]          blue,
    output logic [7:0]          level,
    output logic                frame_last
);
    import lspg_pkg::*;

    localparam logic [5:0] LAST_IDX = 6'(PIXEL_COUNT - 1);
    localparam logic [6:0] COUNT7   = 7'(PIXEL_COUNT);

    frame_cfg_t cfg_reg;
    logic       busy_reg;
    logic [5:0] cnt_reg;
    logic       pix_valid_reg;
    logic [5:0] index_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic [7:0] level_reg;
    logic       last_reg;

    logic       out_adv;
    logic       at_last;
    logic       emit;
    logic       load;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;
    logic [6:0] diff;
    logic [6:0] tail;
    logic       lit_here;
    logic [7:0] glow8;

    assign out_adv    = !pix_valid_reg || !pix_stall;
    assign at_last    = (cnt_reg == LAST_IDX);
    assign emit       = busy_reg && out_adv;
    assign load_ready = !busy_reg || (emit && at_last);
    assign load       = load_valid && load_ready;

    always_comb
    begin
        diff       = {1'b0, cfg_reg.head} - {1'b0, cnt_reg};
        tail       = diff[6] ? diff + COUNT7 : diff;
        lit_here   = ({1'b0, cnt_reg} < cfg_reg.lit);
        glow8      = {2'b00, cfg_reg.glow};
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        unique case (cfg_reg.mode)
            MODE_SLEEP:
            begin
            end
            MODE_LISTENING:
            begin
                if (cfg_reg.muted)
                begin
                    red_next = MUTE_R;
                end
                else if (lit_here)
                begin
                    green_next = LISTEN_G;
                    blue_next  = LISTEN_B;
                end
            end
            MODE_THINKING:
            begin
                if (tail < 7'(COMET_LEN))
                begin
                    red_next   = COMET_R[tail[1:0]];
                    green_next = COMET_G[tail[1:0]];
                end
            end
            MODE_SPEAKING:
            begin
                if (lit_here)
                begin
                    red_next   = SPEAK_R;
                    green_next = SPEAK_G;
                end
            end
            MODE_ERROR:
            begin
                if (cfg_reg.blink)
                begin
                    red_next = ERROR_R;
                end
            end
            MODE_BOOT:
            begin
                if (cnt_reg == cfg_reg.boot_pos)
                begin
                    green_next = BOOT_G;
                    blue_next  = BOOT_B;
                end
            end
            default:
            begin
                // breathing glow
                if (cfg_reg.server_online)
                begin
                    green_next = glow8;
                    blue_next  = {glow8[6:0], 1'b0};
                end
                else
                begin
                    red_next   = {glow8[6:0], 1'b0};
                    green_next = {1'b0, glow8[7:1]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (emit)
            begin
                if (at_last)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            if (out_adv)
            begin
                pix_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cfg_reg <= load_cfg;
        end
        if (emit)
        begin
            index_reg <= cnt_reg;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            level_reg <= brightness;
            last_reg  <= at_last;
        end
    end

    assign pix_valid   = pix_valid_reg;
    assign pixel_index = index_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign level       = level_reg;
    assign frame_last  = last_reg;

endmodule

@@ rtl/core/lspg_checker.sv @@
module lspg_checker #(
    parameter int PIXEL_COUNT = 12
) (
    input logic       clk,
    input logic       rst_n,
    input logic       pix_valid,
    input logic       pix_stall,
    input logic [5:0] pixel_index,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue,
    input logic [7:0] level,
    input logic       frame_last
);
    localparam logic [5:0] LAST_IDX = 6'(PIXEL_COUNT - 1);

    // last flag marks exactly the final pixel
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> (frame_last == (pixel_index == LAST_IDX)))
        else $error("frame_last out of step with pixel_index");

    // pixels of a frame follow without gaps
    a_next_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && !frame_last |=>
            pix_valid && (pixel_index == $past(pixel_index) + 6'd1))
        else $error("pixel word missing or out of order within frame");

    // a new frame starts at pixel zero
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && frame_last |=> !pix_valid || (pixel_index == 6'd0))
        else $error("frame does not start at pixel zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=>
            pix_valid && $stable({pixel_index, red, green, blue, level, frame_last}))
        else $error("stalled pixel word changed");

endmodule

bind led_status_pattern_generator lspg_checker #(.PIXEL_COUNT(PIXEL_COUNT)) u_checker (.*);
